/* hdl/kse_pkg.sv */
// shared widths, codes and status structs for the keypad scan and encoder decode block
package kse_pkg;

  localparam int ROW_W   = 3;
  localparam int PHASE_W = 2;
  localparam int COL_W   = 3;
  localparam int CODE_W  = 5;
  localparam int TURN_W  = 8;

  // active-low row bits within a column sample
  localparam int ROW_FIRST_BIT  = 1;
  localparam int ROW_SECOND_BIT = 2;
  localparam int ROW_THIRD_BIT  = 0;

  localparam logic [ROW_W-1:0]   ROWS_ALL_HIGH = 3'b111;

  // encoder phase codes
  localparam logic [PHASE_W-1:0] PHASE_BOTH_HIGH  = 2'b11;
  localparam logic [PHASE_W-1:0] PHASE_LEFT_FROM  = 2'b10;
  localparam logic [PHASE_W-1:0] PHASE_RIGHT_FROM = 2'b01;

  typedef struct packed {
    logic              press;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] held;
    logic [COL_W-1:0]  column;
  } scan_res_t;

  typedef struct packed {
    logic                     left;
    logic                     right;
    logic signed [TURN_W-1:0] turn;
  } enc_res_t;

endpackage

/* hdl/kse_scan.sv */
// keypad column sweep, row priority, press detect and held key tracking
module kse_scan #(
  parameter int NUM_COLUMNS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [kse_pkg::ROW_W-1:0]  rows,
  output kse_pkg::scan_res_t         res
);

  localparam int CW = kse_pkg::CODE_W;
  localparam logic [CW-1:0] KEY_NONE   = CW'(3 * NUM_COLUMNS);
  localparam logic [CW-1:0] SECOND_ROW = CW'(NUM_COLUMNS);
  localparam logic [CW-1:0] THIRD_ROW  = CW'(2 * NUM_COLUMNS);
  localparam logic [kse_pkg::COL_W-1:0] LAST_COL = kse_pkg::COL_W'(NUM_COLUMNS - 1);

  logic [kse_pkg::COL_W-1:0] col_r, col_nxt;
  logic [kse_pkg::ROW_W-1:0] high_r, high_nxt;
  logic [CW-1:0]             held_r, held_nxt;
  logic [kse_pkg::ROW_W-1:0] high_now;
  logic [CW-1:0]             key;
  logic                      hit;

  always_comb begin
    high_now = high_r & rows;
    hit      = 1'b1;
    key      = CW'(col_r);
    // second row wins, then first, then third
    if (!rows[kse_pkg::ROW_SECOND_BIT]) begin
      key = SECOND_ROW + CW'(col_r);
    end else if (!rows[kse_pkg::ROW_FIRST_BIT]) begin
      key = CW'(col_r);
    end else if (!rows[kse_pkg::ROW_THIRD_BIT]) begin
      key = THIRD_ROW + CW'(col_r);
    end else begin
      hit = 1'b0;
    end

    held_nxt = hit ? key : held_r;
    if (col_r >= LAST_COL) begin
      // end of sweep: release only if no row went low anywhere
      if (high_now == kse_pkg::ROWS_ALL_HIGH) begin
        held_nxt = KEY_NONE;
      end
      high_nxt = kse_pkg::ROWS_ALL_HIGH;
      col_nxt  = '0;
    end else begin
      high_nxt = high_now;
      col_nxt  = col_r + kse_pkg::COL_W'(1);
    end

    res.press  = hit && (held_r == KEY_NONE);
    res.code   = res.press ? key : '0;
    res.held   = held_nxt;
    res.column = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      high_r <= kse_pkg::ROWS_ALL_HIGH;
      held_r <= KEY_NONE;
    end else if (step) begin
      col_r  <= col_nxt;
      high_r <= high_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

/* hdl/kse_enc.sv */
// quadrature step detect and wrapping turn count
module kse_enc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [kse_pkg::PHASE_W-1:0] phase,
  output kse_pkg::enc_res_t           res
);

  logic [kse_pkg::PHASE_W-1:0]       prior_r;
  logic signed [kse_pkg::TURN_W-1:0] turn_r, turn_nxt;

  always_comb begin
    res.left  = (phase == kse_pkg::PHASE_BOTH_HIGH) && (prior_r == kse_pkg::PHASE_LEFT_FROM);
    res.right = (phase == kse_pkg::PHASE_BOTH_HIGH) && (prior_r == kse_pkg::PHASE_RIGHT_FROM);
    turn_nxt  = turn_r;
    if (res.left) begin
      turn_nxt = turn_r - kse_pkg::TURN_W'(1);
    end else if (res.right) begin
      turn_nxt = turn_r + kse_pkg::TURN_W'(1);
    end
    res.turn = turn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= '0;
      turn_r  <= '0;
    end else if (step) begin
      prior_r <= phase;
      turn_r  <= turn_nxt;
    end
  end

endmodule

/* hdl/keypad_scan_and_encoder_decode.sv */
// top level: keypad matrix scan with quadrature encoder decode on stream ports
//
//  channel  | direction | width     | contents
//  in_      | slave     | tdata 8   | one scan tick sample (rows, encoder phases)
//  out_     | master    | tdata 24  | column to drive, codes, held key, turn count
//           |           | tuser 1   | press_valid
//
// every tick passes through the update stage; an item is accepted each cycle while in_tready is high,
// and it moves through the input register, then the result register
// the scan and encoder state advance when an item moves from the input register
// into the result register, so state never runs ahead of delivered results
// a stalled out_tready holds the result register; one more item waits in the
// input register, then in_tready drops until the result is taken
// synchronous active-low reset clears both registers' valid flags and all state
module keypad_scan_and_encoder_decode #(
  parameter int NUM_COLUMNS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // row_levels[2:0], phase_levels[4:3], zero [7:5]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // drive_column[2:0], press_code[7:3], held_key[12:8],
                                  // turn_count[20:13], zero [23:21]
  output logic [0:0]  out_tuser   // press_valid[0]
);

  localparam int CW = kse_pkg::CODE_W;
  // encoder codes follow the three key rows
  localparam logic [CW-1:0] CODE_ENC_LEFT  = CW'(3 * NUM_COLUMNS);
  localparam logic [CW-1:0] CODE_ENC_RIGHT = CW'(3 * NUM_COLUMNS + 1);

  // input register
  logic                          s1_valid_r;
  logic [kse_pkg::ROW_W-1:0]     rows_r;
  logic [kse_pkg::PHASE_W-1:0]   phase_r;

  // result register
  logic                          out_valid_r;
  logic [23:0]                   out_data_r, out_data_nxt;
  logic                          press_valid_r, press_valid_nxt;

  logic                          in_fire;
  logic                          out_load;
  logic                          advance;

  kse_pkg::scan_res_t            scan_res;
  kse_pkg::enc_res_t             enc_res;
  logic [CW-1:0]                 code_nxt;

  assign out_load  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  kse_scan #(
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .rows  (rows_r),
    .res   (scan_res)
  );

  kse_enc u_enc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .phase (phase_r),
    .res   (enc_res)
  );

  // an encoder step overrides a key press of the same tick
  always_comb begin
    code_nxt        = scan_res.code;
    press_valid_nxt = scan_res.press || enc_res.left || enc_res.right;
    if (enc_res.left) begin
      code_nxt = CODE_ENC_LEFT;
    end else if (enc_res.right) begin
      code_nxt = CODE_ENC_RIGHT;
    end
    out_data_nxt = {3'b000, enc_res.turn, scan_res.held, code_nxt, scan_res.column};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      rows_r  <= in_tdata[2:0];
      phase_r <= in_tdata[4:3];
    end
    if (advance) begin
      out_data_r    <= out_data_nxt;
      press_valid_r <= press_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = press_valid_r;

`ifndef SYNTHESIS
  // held key is a valid index or the none code
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[12:8] <= CODE_ENC_LEFT))
    else $error("held key out of range");

  // no event means a zero code
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !press_valid_r) |-> (out_data_r[7:3] == '0))
    else $error("press code set without event");

  // driven column stays inside the matrix
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_data_r[2:0]} < 4'(NUM_COLUMNS)))
    else $error("drive column out of range");

  // input backpressure only when both registers are full and output stalls
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("in_tready low without a full pipeline");
`endif

endmodule

/* tb/testbench.sv */
// testbench for keypad_scan_and_encoder_decode: directed and random scan ticks checked by a scoreboard
`timescale 1ns / 1ps

module testbench;
  import kse_pkg::*;

  localparam int NUM_COLS    = 6;
  localparam int KEY_NONE    = 3 * NUM_COLS;      // held index when nothing is held
  localparam int CODE_LEFT   = 3 * NUM_COLS;      // encoder step left
  localparam int CODE_RIGHT  = 3 * NUM_COLS + 1;  // encoder step right
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  // one expected result item, fields as they come out of the block
  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic              press;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] held;
    logic [TURN_W-1:0] turn;
  } tick_result_t;

  // tracks scan and encoder state, predicts one result per accepted tick
  class scan_scoreboard;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   rows_seen;
    logic [CODE_W-1:0]  held;
    logic [PHASE_W-1:0] last_phase;
    logic [TURN_W-1:0]  turns;
    tick_result_t       pending_results[$];
    int                 errors;

    function new();
      column     = '0;
      rows_seen  = ROWS_ALL_HIGH;
      held       = CODE_W'(KEY_NONE);
      last_phase = '0;
      turns      = '0;
      errors     = 0;
    endfunction

    function void note_tick(logic [ROW_W-1:0] rows, logic [PHASE_W-1:0] phase);
      tick_result_t r;
      int           seen;
      seen    = KEY_NONE;
      r.press = 1'b0;
      r.code  = '0;
      rows_seen &= rows;
      // second row wins over first, first over third
      if (!rows[ROW_SECOND_BIT]) begin
        seen = NUM_COLS + column;
      end else if (!rows[ROW_FIRST_BIT]) begin
        seen = column;
      end else if (!rows[ROW_THIRD_BIT]) begin
        seen = 2 * NUM_COLS + column;
      end
      if (seen != KEY_NONE) begin
        if (held == KEY_NONE) begin
          r.press = 1'b1;
          r.code  = CODE_W'(seen);
        end
        held = CODE_W'(seen);
      end
      // end of sweep: release only if no row went low anywhere in it
      if (column == NUM_COLS - 1) begin
        if (rows_seen == ROWS_ALL_HIGH) held = CODE_W'(KEY_NONE);
        rows_seen = ROWS_ALL_HIGH;
        column    = '0;
      end else begin
        column = column + 1'b1;
      end
      // an encoder step replaces any key event of the same tick
      if (phase == PHASE_BOTH_HIGH && last_phase == PHASE_LEFT_FROM) begin
        turns   = turns - 1'b1;
        r.press = 1'b1;
        r.code  = CODE_W'(CODE_LEFT);
      end else if (phase == PHASE_BOTH_HIGH && last_phase == PHASE_RIGHT_FROM) begin
        turns   = turns + 1'b1;
        r.press = 1'b1;
        r.code  = CODE_W'(CODE_RIGHT);
      end
      last_phase = phase;
      r.column   = column;
      r.held     = held;
      r.turn     = turns;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [23:0] data, logic [0:0] user);
      tick_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data %h user %h",
                 $time, data, user);
      end else begin
        want = pending_results.pop_front();
        compare_field("drive_column", want.column, data[2:0]);
        compare_field("press_code",   want.code,   data[7:3]);
        compare_field("held_key",     want.held,   data[12:8]);
        compare_field("turn_count",   want.turn,   data[20:13]);
        compare_field("tdata pad",    0,           data[23:21]);
        compare_field("press_valid",  want.press,  user[0]);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  scan_scoreboard sb = new();
  int             cycle_count = 0;
  int             ticks_sent  = 0;
  int             next_column = 0;  // column the block will drive for the next item sent
  int             in_calm     = 0;  // items left in a no-gap stretch, sender side
  int             out_calm    = 0;  // same for the receiver

  // directed sweep: idle, several rows low, held key moving, release after a quiet sweep,
  // key on the final column, left and right steps, repeated 11, encoder over a press
  logic [ROW_W-1:0]   dir_rows  [25] = '{7, 0, 5, 7, 7, 7,  7, 7, 7, 7, 7, 7,
                                         7, 7, 7, 7, 7, 6,  7, 7, 7, 7, 7, 7, 3};
  logic [PHASE_W-1:0] dir_phase [25] = '{0, 0, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0,
                                         0, 0, 0, 0, 0, 0,  2, 3, 1, 3, 3, 1, 3};

  keypad_scan_and_encoder_decode #(.NUM_COLUMNS(NUM_COLS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // row_levels[2:0], phase_levels[4:3], zero [7:5]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // drive_column[2:0], press_code[7:3], held_key[12:8],
                               // turn_count[20:13], zero [23:21]
    .out_tuser  (out_tuser)    // press_valid[0]
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // handshakes are sampled with pre-edge values; drives all use nonblocking updates
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_tick(in_tdata[2:0], in_tdata[4:3]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // draw a random wait before the next item, with occasional stretches of back-to-back items
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // offer one scan tick and hold it until the block takes it
  task automatic send_tick(input logic [ROW_W-1:0] rows, input logic [PHASE_W-1:0] phase);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, phase, rows};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
    next_column = (next_column + 1) % NUM_COLS;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly released rows, now and then a random pattern
  function automatic logic [ROW_W-1:0] quiet_rows();
    return ($urandom_range(0, 5) == 0) ? ROW_W'($urandom_range(0, 7)) : ROWS_ALL_HIGH;
  endfunction

  // one key held over a few sweeps; low only while its column is driven
  task automatic key_burst();
    int                 key_col;
    int                 key_row_bit;
    int                 len;
    logic [ROW_W-1:0]   rows;
    logic [PHASE_W-1:0] phase;
    key_col     = $urandom_range(0, NUM_COLS - 1);
    key_row_bit = $urandom_range(0, ROW_W - 1);
    len         = $urandom_range(6, 20);
    phase       = PHASE_W'($urandom_range(0, 3));
    repeat (len) begin
      rows = ROWS_ALL_HIGH;
      if (next_column == key_col) begin
        rows[key_row_bit] = 1'b0;
        // sometimes a second key in the same column
        if ($urandom_range(0, 3) == 0) rows[$urandom_range(0, ROW_W - 1)] = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) rows = ROW_W'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) phase = PHASE_W'($urandom_range(0, 3));
      send_tick(rows, phase);
    end
  endtask

  // gray-code rotation, one detent per four phase samples
  task automatic gray_burst();
    logic [PHASE_W-1:0] right_seq [4] = '{2'b00, 2'b01, 2'b11, 2'b10};
    logic [PHASE_W-1:0] left_seq  [4] = '{2'b00, 2'b10, 2'b11, 2'b01};
    bit                 go_right;
    int                 steps;
    go_right = $urandom_range(0, 1);
    steps    = $urandom_range(1, 12);
    repeat (steps) begin
      for (int i = 0; i < 4; i++) begin
        send_tick(quiet_rows(), go_right ? right_seq[i] : left_seq[i]);
      end
    end
  endtask

  // fast detents (from, 11) pairs, long enough to wrap the count
  task automatic detent_run(input bit go_right, input int steps);
    repeat (steps) begin
      send_tick(quiet_rows(), go_right ? PHASE_RIGHT_FROM : PHASE_LEFT_FROM);
      send_tick(quiet_rows(), PHASE_BOTH_HIGH);
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 10)) begin
      send_tick(ROW_W'($urandom_range(0, 7)), PHASE_W'($urandom_range(0, 3)));
    end
  endtask

  // receiver: random stall before each result, with stretches of none
  initial begin
    int stall;
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("** keypad_scan_and_encoder_decode: FAILED **");
    $finish;
  end

  initial begin
    int random_start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < 25; i++) send_tick(dir_rows[i], dir_phase[i]);

    // hold off until the block has delivered everything
    in_tvalid <= 1'b0;
    wait_drained();

    // random part: wrap upward, mixed traffic, wrap downward, mixed traffic
    random_start = ticks_sent;
    detent_run(1'b1, 135);
    while (ticks_sent - random_start < 520) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: key_burst();
        4, 5, 6:    gray_burst();
        default:    noise_burst();
      endcase
    end
    detent_run(1'b0, 300);
    while (ticks_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: key_burst();
        4, 5, 6:    gray_burst();
        default:    noise_burst();
      endcase
    end
    in_tvalid <= 1'b0;

    // drain, then keep watching the output to catch anything extra
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.errors++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, sb.pending_results.size());
    end

    if (sb.errors == 0) begin
      $display("** keypad_scan_and_encoder_decode: PASSED **");
    end else begin
      $display("** keypad_scan_and_encoder_decode: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/kse_pkg.sv
hdl/kse_scan.sv
hdl/kse_enc.sv
hdl/keypad_scan_and_encoder_decode.sv
tb/testbench.sv
